/* sv/stp_pkg.sv */
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants for the stepper profile generator
// Item and result layouts, controller/datapath command set, fixed widths.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int CountBits  = 24;
    localparam int SumBits    = CountBits + 1;
    localparam int GoalBits   = 25;
    localparam int CmpBits    = (SumBits > GoalBits) ? SumBits : GoalBits;
    localparam int ProdBits   = SumBits + 16;
    localparam int RemBits    = (ProdBits + 1 > 42) ? ProdBits + 1 : 42;
    localparam int DivBits    = 33;
    localparam int DivCntBits = 6;
    localparam int KBits      = 23;
    localparam int MulCntBits = 5;
    localparam int MulBits    = 66;
    localparam int NumBits    = 51;

    localparam logic [11:0] FloorReset = 12'd30;
    localparam logic [7:0]  AccelReset = 8'd24;
    localparam logic [15:0] PulseReset = 16'd5147;
    localparam logic [15:0] RateReset  = 16'd381;
    localparam logic [14:0] KScale     = 15'd32000;

    localparam logic [1:0] CFG_FLOOR = 2'd0;
    localparam logic [1:0] CFG_ACCEL = 2'd1;
    localparam logic [1:0] CFG_PULSE = 2'd2;

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_RIGHT  = 3'd1;
    localparam logic [2:0] FUNC_LEFT   = 3'd2;
    localparam logic [2:0] FUNC_ACCEL  = 3'd3;
    localparam logic [2:0] FUNC_CRUISE = 3'd4;
    localparam logic [2:0] FUNC_DECEL  = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACCEL,
        PH_CRUISE,
        PH_DECEL
    } t_phase;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] length_mm;
        logic [11:0] target_speed;
    } t_item;

    typedef struct packed {
        logic [15:0] rate_left;
        logic [15:0] rate_right;
        logic        moving;
        logic        phase_done;
        logic        braking;
    } t_res;

    typedef struct packed {
        logic apply;
        logic div_start;
        logic div_goal;
        logic div_step;
        logic div_write;
        logic chk_prep;
        logic chk_rem;
        logic mul_step;
        logic finish;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic motor_on;
        logic chk_needed;
        logic div_last;
        logic mul_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* sv/stp_dp.sv */
// ----------------------------------------------------------------------------
// stp_dp: profile datapath
// Motion state, config registers, iterative divider, shift-add multiplier
// for the braking test, and the result register.
// ----------------------------------------------------------------------------
module stp_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stp_pkg::t_item    i_item,
    input  stp_pkg::t_dp_cmd  i_cmd,
    output stp_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output stp_pkg::t_res     o_res
);
    import stp_pkg::*;

    localparam logic signed [RemBits-1:0] RemHi = RemBits'(64'h100_0000_0000);
    localparam logic signed [RemBits-1:0] RemLo = -RemHi;

    logic [11:0]           r_floor;
    logic [7:0]            r_accel;
    logic [15:0]           r_pulse;
    logic [15:0]           r_speed;
    logic [11:0]           r_ceil;
    logic [11:0]           r_low;
    logic signed [8:0]     r_cacc;
    logic [CountBits-1:0]  r_right;
    logic [CountBits-1:0]  r_left;
    logic [GoalBits-1:0]   r_goal;
    logic [15:0]           r_len;
    logic [15:0]           r_rate;
    t_phase                r_phase;
    logic                  r_motor;
    logic                  r_brake;

    logic [DivBits-1:0]    r_dquo;
    logic [15:0]           r_drem;
    logic [DivCntBits-1:0] r_dcnt;
    logic                  r_dgoal;

    logic [ProdBits-1:0]   r_prod;
    logic [31:0]           r_cs2;
    logic [23:0]           r_f2;
    logic [KBits-1:0]      r_k;
    logic signed [NumBits-1:0] r_num;
    logic signed [MulBits-1:0] r_macc;
    logic signed [MulBits-1:0] r_ma;
    logic [KBits-1:0]      r_mk;
    logic [MulCntBits-1:0] r_mcnt;

    t_res                  r_out;
    logic                  r_out_valid;

    logic [15:0]               pnz;
    logic [SumBits-1:0]        sum;
    logic                      done;
    logic signed [17:0]        tick_s;
    logic signed [17:0]        tick_hi;
    logic signed [17:0]        tick_lo;
    logic signed [17:0]        tick_c;
    logic [16:0]               pr;
    logic                      ge;
    logic signed [RemBits-1:0] rem_w;
    logic signed [RemBits-1:0] rem_c;
    logic signed [33:0]        num_d;
    logic                      gt;
    logic                      brake_n;
    logic                      is_cmd;

    assign pnz    = (r_pulse == 16'd0) ? 16'd1 : r_pulse;
    assign sum    = {1'b0, r_right} + {1'b0, r_left};
    assign done   = CmpBits'(sum) >= CmpBits'(r_goal);
    assign is_cmd = (i_item.func == FUNC_ACCEL) || (i_item.func == FUNC_CRUISE)
                    || (i_item.func == FUNC_DECEL);

    always_comb begin
        tick_s  = $signed({2'b00, r_speed}) + 18'(r_cacc);
        tick_hi = $signed({2'b00, r_ceil, 4'b0000});
        tick_lo = $signed({2'b00, r_low, 4'b0000});
        tick_c  = tick_s;
        if (tick_c > tick_hi) begin
            tick_c = tick_hi;
        end
        if (tick_c < tick_lo) begin
            tick_c = tick_lo;
        end
    end

    assign pr = {r_drem, r_dquo[DivBits-1]};
    assign ge = pr >= {1'b0, pnz};

    always_comb begin
        rem_w = $signed(RemBits'({r_len, 17'd0})) - $signed(RemBits'(r_prod));
        rem_c = rem_w;
        if (rem_w > RemHi) begin
            rem_c = RemHi;
        end
        if (rem_w < RemLo) begin
            rem_c = RemLo;
        end
    end

    assign num_d   = $signed({2'b00, r_cs2}) - $signed({2'b00, r_f2, 8'd0});
    assign gt      = r_macc > MulBits'(r_num);
    assign brake_n = r_brake || !gt;

    assign o_stat.motor_on   = r_motor;
    assign o_stat.chk_needed = (r_phase == PH_DECEL) && !r_brake;
    assign o_stat.div_last   = r_dcnt == DivCntBits'(DivBits - 1);
    assign o_stat.mul_last   = r_mcnt == MulCntBits'(KBits - 1);
    assign o_stat.out_free   = !r_out_valid || i_res_ready;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor     <= FloorReset;
            r_accel     <= AccelReset;
            r_pulse     <= PulseReset;
            r_speed     <= {FloorReset, 4'd0};
            r_ceil      <= '0;
            r_low       <= FloorReset;
            r_cacc      <= '0;
            r_right     <= '0;
            r_left      <= '0;
            r_goal      <= '0;
            r_len       <= '0;
            r_rate      <= RateReset;
            r_phase     <= PH_IDLE;
            r_motor     <= 1'b0;
            r_brake     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FLOOR: r_floor <= i_cfg_data[11:0];
                    CFG_ACCEL: r_accel <= i_cfg_data[7:0];
                    CFG_PULSE: r_pulse <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.apply) begin
                if (i_item.func == FUNC_TICK) begin
                    if (r_motor) begin
                        r_speed <= tick_c[15:0];
                    end
                end else if (i_item.func == FUNC_RIGHT) begin
                    if (r_motor && r_right != '1) begin
                        r_right <= r_right + 1'b1;
                    end
                end else if (i_item.func == FUNC_LEFT) begin
                    if (r_motor && r_left != '1) begin
                        r_left <= r_left + 1'b1;
                    end
                end else if (is_cmd) begin
                    r_ceil  <= i_item.target_speed;
                    r_right <= '0;
                    r_left  <= '0;
                    r_len   <= i_item.length_mm;
                    r_brake <= 1'b0;
                    if (i_item.func == FUNC_ACCEL) begin
                        r_cacc  <= $signed({1'b0, r_accel});
                        r_low   <= r_floor;
                        r_speed <= {r_floor, 4'd0};
                        r_motor <= 1'b1;
                        r_phase <= PH_ACCEL;
                    end else begin
                        r_cacc  <= '0;
                        r_low   <= i_item.target_speed;
                        r_speed <= {i_item.target_speed, 4'd0};
                        r_phase <= (i_item.func == FUNC_CRUISE) ? PH_CRUISE : PH_DECEL;
                    end
                end
            end

            if (i_cmd.div_write) begin
                if (r_dgoal) begin
                    r_goal <= (|r_dquo[DivBits-1:GoalBits]) ? '1 : r_dquo[GoalBits-1:0];
                end else begin
                    r_rate <= (|r_dquo[DivBits-1:16]) ? 16'hFFFF : r_dquo[15:0];
                end
            end

            if (i_cmd.finish && r_phase == PH_DECEL) begin
                if (!r_brake && !gt) begin
                    r_brake <= 1'b1;
                    r_cacc  <= -$signed({1'b0, r_accel});
                    r_low   <= r_floor;
                end
                if (brake_n && done) begin
                    r_motor <= 1'b0;
                    r_phase <= PH_IDLE;
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dquo  <= i_cmd.div_goal ? DivBits'({r_len, 17'd0})
                                      : DivBits'({r_speed, 12'd0});
            r_drem  <= '0;
            r_dcnt  <= '0;
            r_dgoal <= i_cmd.div_goal;
        end else if (i_cmd.div_step) begin
            r_drem <= ge ? 16'(pr - {1'b0, pnz}) : pr[15:0];
            r_dquo <= {r_dquo[DivBits-2:0], ge};
            r_dcnt <= r_dcnt + 1'b1;
        end

        if (i_cmd.chk_prep) begin
            r_prod <= {16'd0, sum} * {25'd0, pnz};
            r_cs2  <= {16'd0, r_speed} * {16'd0, r_speed};
            r_f2   <= {12'd0, r_floor} * {12'd0, r_floor};
            r_k    <= {15'd0, r_accel} * {8'd0, KScale};
        end

        if (i_cmd.chk_rem) begin
            r_ma   <= MulBits'(rem_c);
            r_num  <= NumBits'(num_d) <<< 17;
            r_macc <= '0;
            r_mk   <= r_k;
            r_mcnt <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mk[0]) begin
                r_macc <= r_macc + r_ma;
            end
            r_ma   <= r_ma <<< 1;
            r_mk   <= r_mk >> 1;
            r_mcnt <= r_mcnt + 1'b1;
        end

        if (i_cmd.load_out) begin
            r_out.rate_left  <= r_rate;
            r_out.rate_right <= r_rate;
            r_out.moving     <= r_motor;
            r_out.phase_done <= done;
            r_out.braking    <= r_brake;
        end
    end

endmodule

/* sv/stp_ctrl.sv */
// ----------------------------------------------------------------------------
// stp_ctrl: profile sequencer
// Steps one item through update, divisions, braking test and result load.
// ----------------------------------------------------------------------------
module stp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  logic [2:0]        i_func,
    input  stp_pkg::t_dp_stat i_stat,
    output logic              o_item_ready,
    output stp_pkg::t_dp_cmd  o_cmd
);
    import stp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DSTART,
        S_DIV,
        S_DWR,
        S_CHK,
        S_PREP,
        S_REM,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_rate_pend;
    logic   r_goal_pend;
    logic   accept;
    logic   is_cmd;

    assign o_item_ready = r_state == S_IDLE;
    assign accept       = i_item_valid && o_item_ready;
    assign is_cmd       = (i_func == FUNC_ACCEL) || (i_func == FUNC_CRUISE)
                          || (i_func == FUNC_DECEL);

    always_comb begin
        o_cmd           = '0;
        o_cmd.apply     = accept;
        o_cmd.div_start = r_state == S_DSTART;
        o_cmd.div_goal  = !r_rate_pend;
        o_cmd.div_step  = r_state == S_DIV;
        o_cmd.div_write = r_state == S_DWR;
        o_cmd.chk_prep  = r_state == S_PREP;
        o_cmd.chk_rem   = r_state == S_REM;
        o_cmd.mul_step  = r_state == S_MUL;
        o_cmd.finish    = r_state == S_FIN;
        o_cmd.load_out  = (r_state == S_OUT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate_pend <= 1'b0;
            r_goal_pend <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (is_cmd) begin
                            r_rate_pend <= 1'b1;
                            r_goal_pend <= 1'b1;
                            r_state     <= S_DSTART;
                        end else if (i_func == FUNC_TICK && i_stat.motor_on) begin
                            r_rate_pend <= 1'b1;
                            r_goal_pend <= 1'b0;
                            r_state     <= S_DSTART;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (i_stat.div_last) begin
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    if (r_rate_pend) begin
                        r_rate_pend <= 1'b0;
                        r_state     <= r_goal_pend ? S_DSTART : S_CHK;
                    end else begin
                        r_goal_pend <= 1'b0;
                        r_state     <= S_CHK;
                    end
                end
                S_CHK:  r_state <= i_stat.chk_needed ? S_PREP : S_FIN;
                S_PREP: r_state <= S_REM;
                S_REM:  r_state <= S_MUL;
                S_MUL: begin
                    if (i_stat.mul_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: r_state <= S_OUT;
                S_OUT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* sv/stepper_trapezoid_profile.sv */
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile: trapezoidal speed profile for two stepper wheels
// One item in, one result out; items are processed one at a time. A step
// pulse runs no division; a tick with the motors on runs one radix-2
// division for the step rate; a command runs the rate and step-goal
// divisions back to back. In a decelerate segment before braking starts,
// the braking test is added, a shift-add multiply of remaining distance by
// the acceleration term. A result waiting in the output register holds off
// only the end of the next item, not its start.
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  stp_pkg::t_item i_item,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output stp_pkg::t_res  o_res,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    import stp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    stp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .i_func       (i_item.func),
        .i_stat       (stat),
        .o_item_ready (o_item_ready),
        .o_cmd        (cmd)
    );

    stp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_res_ready (i_res_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

/* sv/stp_check.sv */
// ----------------------------------------------------------------------------
// stp_check: port-level checks for the profile generator
// Result handshake, one-at-a-time intake, and matching wheel rates.
// ----------------------------------------------------------------------------
module stp_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_item_valid,
    input logic           o_item_ready,
    input logic           o_res_valid,
    input logic           i_res_ready,
    input stp_pkg::t_res  o_res
);
    import stp_pkg::*;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result dropped before transfer");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> $stable(o_res))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && o_item_ready |=> !o_item_ready)
        else $error("second item taken while one is in work");

    a_rates_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.rate_left == o_res.rate_right)
        else $error("wheel rates differ");

endmodule

bind stepper_trapezoid_profile stp_check u_stp_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item_valid),
    .o_item_ready (o_item_ready),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_res        (o_res)
);

/* test/stepper_trapezoid_profile_tb.sv */
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile_tb: self-checking bench for the profile generator
// Drives ticks, step pulses and segment commands through the item channel,
// predicts every result with an in-bench profile model and compares each
// result transfer against it as a whole. Both sides idle at random.
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile_tb;
    import stp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_item_valid;
    logic        o_item_ready;
    t_item       i_item;
    logic        o_res_valid;
    logic        i_res_ready;
    t_res        o_res;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    stepper_trapezoid_profile i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_ready (o_item_ready),
        .i_item       (i_item),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    localparam longint CountMax  = (64'd1 << CountBits) - 1;
    localparam longint GoalMax   = 64'h1FFFFFF;
    localparam longint RemLimit  = 64'd1 << 40;
    localparam int     CycleLimit = 2000000;

    // profile state
    logic [11:0] floor_spd;
    logic [7:0]  accel_reg;
    logic [15:0] pulse_reg;
    logic [15:0] speed;
    logic [11:0] ceil_spd;
    logic [11:0] lo_spd;
    int          accel_now;
    longint      r_steps;
    longint      l_steps;
    longint      goal;
    logic [15:0] seg_len;
    logic [15:0] rate;
    t_phase      phase;
    logic        motor;
    logic        brake;

    t_res res_q[$];
    int   n_fail;
    int   n_items;
    int   n_results;
    int   cycles;
    int   res_wait;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout at %0t", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint pulse_nz();
        return (pulse_reg == 16'd0) ? 64'd1 : longint'(pulse_reg);
    endfunction

    function automatic logic [15:0] rate_for(logic [15:0] s);
        longint r;
        r = (longint'(s) << 12) / pulse_nz();
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    task automatic model_reset();
        floor_spd = FloorReset;
        accel_reg = AccelReset;
        pulse_reg = PulseReset;
        speed = {floor_spd, 4'd0};
        ceil_spd = '0;
        lo_spd = floor_spd;
        accel_now = 0;
        r_steps = 0;
        l_steps = 0;
        goal = 0;
        seg_len = '0;
        rate = rate_for(speed);
        phase = PH_IDLE;
        motor = 1'b0;
        brake = 1'b0;
    endtask

    task automatic predict_profile(t_item it);
        longint g, rem, cs, f, num, k;
        int     s, hi, lo;
        t_res   r;
        case (it.func)
            FUNC_TICK: begin
                if (motor) begin
                    s = int'(speed) + accel_now;
                    hi = int'(ceil_spd) * 16;
                    lo = int'(lo_spd) * 16;
                    if (s > hi) s = hi;
                    if (s < lo) s = lo;
                    speed = s[15:0];
                    rate = rate_for(speed);
                end
            end
            FUNC_RIGHT: if (motor && r_steps < CountMax) r_steps++;
            FUNC_LEFT:  if (motor && l_steps < CountMax) l_steps++;
            FUNC_ACCEL, FUNC_CRUISE, FUNC_DECEL: begin
                g = (longint'(it.length_mm) << 17) / pulse_nz();
                ceil_spd = it.target_speed;
                r_steps = 0;
                l_steps = 0;
                seg_len = it.length_mm;
                brake = 1'b0;
                if (it.func == FUNC_ACCEL) begin
                    accel_now = int'(accel_reg);
                    lo_spd = floor_spd;
                    speed = {floor_spd, 4'd0};
                    motor = 1'b1;
                    phase = PH_ACCEL;
                end else begin
                    accel_now = 0;
                    lo_spd = it.target_speed;
                    speed = {it.target_speed, 4'd0};
                    phase = (it.func == FUNC_CRUISE) ? PH_CRUISE : PH_DECEL;
                end
                rate = rate_for(speed);
                goal = (g > GoalMax) ? GoalMax : g;
            end
            default: ;
        endcase
        if (phase == PH_DECEL) begin
            if (!brake) begin
                rem = (longint'(seg_len) << 17) - (r_steps + l_steps) * pulse_nz();
                cs = longint'(speed);
                f = longint'(floor_spd);
                num = (cs * cs - 256 * f * f) * 131072;
                k = 32000 * longint'(accel_reg);
                if (rem > RemLimit) rem = RemLimit;
                if (rem < -RemLimit) rem = -RemLimit;
                if (!(rem * k > num)) begin
                    brake = 1'b1;
                    accel_now = -int'(accel_reg);
                    lo_spd = floor_spd;
                end
            end
            if (brake && (r_steps + l_steps) >= goal) begin
                motor = 1'b0;
                phase = PH_IDLE;
            end
        end
        r.rate_left = rate;
        r.rate_right = rate;
        r.moving = motor;
        r.phase_done = ((r_steps + l_steps) >= goal);
        r.braking = brake;
        res_q.push_back(r);
    endtask

    task automatic send_item(logic [2:0] fn, logic [15:0] len, logic [11:0] tar);
        t_item it;
        int    gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_item_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.func = fn;
        it.length_mm = len;
        it.target_speed = tar;
        i_item <= it;
        i_item_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_item_ready) @(posedge i_clk);
        predict_profile(it);
        n_items++;
    endtask

    task automatic drain();
        i_item_valid <= 1'b0;
        while (res_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FLOOR: floor_spd = val[11:0];
            CFG_ACCEL: accel_reg = val[7:0];
            CFG_PULSE: pulse_reg = val;
            default: ;
        endcase
    endtask

    // result side: random wait per result, compare with oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        int   w;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            n_results++;
            if (res_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_res);
                n_fail++;
            end else begin
                e = res_q.pop_front();
                if (o_res !== e) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, o_res);
                    n_fail++;
                end
            end
        end
        if (o_res_valid && i_res_ready) begin
            w = $urandom_range(0, 6);
            res_wait <= w;
            i_res_ready <= (w == 0);
        end else if (o_res_valid && res_wait > 0) begin
            res_wait <= res_wait - 1;
            i_res_ready <= (res_wait == 1);
        end else if (res_wait == 0) begin
            i_res_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_item(FUNC_TICK, 16'd0, 12'd0);
        send_item(FUNC_RIGHT, 16'hFFFF, 12'hFFF);
        send_item(FUNC_CRUISE, 16'd10, 12'd100);
        send_item(FUNC_RIGHT, 16'd0, 12'd0);
        send_item(3'd6, 16'hFFFF, 12'hFFF);
        send_item(3'd7, 16'd0, 12'd0);
        send_item(FUNC_ACCEL, 16'd0, 12'd0);
        send_item(FUNC_TICK, 16'd0, 12'd0);
        send_item(FUNC_ACCEL, 16'hFFFF, 12'hFFF);
        repeat (4) send_item(FUNC_TICK, 16'd0, 12'd0);
        send_item(FUNC_DECEL, 16'd1, 12'd20);
        repeat (3) send_item(FUNC_RIGHT, 16'd0, 12'd0);
        repeat (3) send_item(FUNC_LEFT, 16'd0, 12'd0);
        send_item(FUNC_ACCEL, 16'd3, 12'd5);
        repeat (3) send_item(FUNC_TICK, 16'd0, 12'd0);
        send_item(FUNC_DECEL, 16'hFFFF, 12'hFFF);
        send_item(FUNC_TICK, 16'd0, 12'd0);
    endtask

    task automatic test_extremes();
        write_reg(CFG_PULSE, 16'd0);
        send_item(FUNC_ACCEL, 16'hFFFF, 12'hFFF);
        send_item(FUNC_TICK, 16'd0, 12'd0);
        write_reg(CFG_PULSE, 16'd1);
        write_reg(CFG_ACCEL, 16'd0);
        write_reg(CFG_FLOOR, 16'hFFF);
        send_item(FUNC_ACCEL, 16'd2, 12'd10);
        send_item(FUNC_TICK, 16'd0, 12'd0);
        send_item(FUNC_DECEL, 16'd0, 12'd0);
        send_item(FUNC_RIGHT, 16'd0, 12'd0);
        write_reg(CFG_ACCEL, 16'hFF);
        write_reg(CFG_FLOOR, 16'd0);
        write_reg(CFG_PULSE, 16'hFFFF);
        send_item(FUNC_ACCEL, 16'd50, 12'hFFF);
        repeat (3) send_item(FUNC_TICK, 16'd0, 12'd0);
        send_item(FUNC_DECEL, 16'd1, 12'hFFF);
        repeat (3) send_item(FUNC_LEFT, 16'd0, 12'd0);
    endtask

    // full move: accelerate, cruise, decelerate with steps, ticks and random codes mixed in
    task automatic run_move(int steps_per_seg);
        logic [2:0]  fn;
        logic [15:0] len;
        int          r;
        len = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
        for (int seg = 0; seg < 3; seg++) begin
            fn = (seg == 0) ? FUNC_ACCEL : (seg == 1) ? FUNC_CRUISE : FUNC_DECEL;
            send_item(fn, len, 12'($urandom));
            for (int j = 0; j < steps_per_seg; j++) begin
                r = $urandom_range(0, 9);
                if (r < 4) send_item(FUNC_TICK, 16'($urandom), 12'($urandom));
                else if (r < 7) send_item(FUNC_RIGHT, 16'($urandom), 12'($urandom));
                else if (r < 9) send_item(FUNC_LEFT, 16'($urandom), 12'($urandom));
                else send_item(3'($urandom), 16'($urandom), 12'($urandom));
            end
        end
    endtask

    task automatic test_random(int n_target);
        while (n_items < n_target) begin
            if ($urandom_range(0, 7) == 0) begin
                write_reg(2'($urandom_range(0, 2)), 16'($urandom));
                if (pulse_reg < 16'd256) write_reg(CFG_PULSE, 16'($urandom_range(1, 9000)));
            end
            run_move($urandom_range(2, 12));
            if ($urandom_range(0, 9) == 0) drain();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        n_fail = 0;
        n_items = 0;
        n_results = 0;
        cycles = 0;
        res_wait = 0;
        i_rst_n = 1'b0;
        i_item_valid = 1'b0;
        i_item = '0;
        i_res_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FLOOR;
        i_cfg_data = '0;
        model_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extremes();
        write_reg(CFG_FLOOR, 16'd30);
        write_reg(CFG_ACCEL, 16'd24);
        write_reg(CFG_PULSE, 16'd5147);
        test_random(900);
        drain();
        $display("Sent %0d items across segment commands, pulses and ticks;", n_items);
        $display("checked %0d results under several register settings.", n_results);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
sv/stp_pkg.sv
sv/stp_dp.sv
sv/stp_ctrl.sv
sv/stepper_trapezoid_profile.sv
sv/stp_check.sv
test/stepper_trapezoid_profile_tb.sv
